/* rtl/crcfd_pkg.sv */
// ---------------------------------------------------------------------------
// crcfd_pkg
// Shared types, constants and the CRC-8 byte update for the frame decoder.
// ---------------------------------------------------------------------------
package crcfd_pkg;

    localparam int WORD_W   = 16;
    localparam int BYTE_W   = 8;
    localparam int TDIV_W   = 15;
    localparam int WCNT_W   = 2;
    localparam int STAT_W   = 2;
    localparam int CFG_W    = 15;
    localparam int OUT_W    = 56;

    localparam logic [7:0]  CRC_INIT = 8'hFF;
    localparam logic [7:0]  CRC_POLY = 8'h31;

    localparam logic [WCNT_W-1:0] WCNT_RESET = 2'd3;
    localparam logic [TDIV_W-1:0] TDIV_RESET = 15'd200;

    // configuration register indexes
    localparam logic CFG_WORD_COUNT = 1'b0;
    localparam logic CFG_TEMP_DIV   = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_CRC  = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_ZERO = 2'd2;

    typedef struct packed {
        logic                     start;
        logic signed [WORD_W-1:0] num;
        logic signed [WORD_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [WORD_W-1:0] quo;
    } div_rsp_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

/* rtl/crcfd_div.sv */
// ---------------------------------------------------------------------------
// crcfd_div
// Radix-2 restoring signed divider, one quotient bit per cycle, truncating,
// with the single overflow case saturated to the largest positive value.
// ---------------------------------------------------------------------------
module crcfd_div (
    input  logic               clk,
    input  logic               rst_n,
    input  crcfd_pkg::div_req_t req,
    output crcfd_pkg::div_rsp_t rsp
);
    import crcfd_pkg::*;

    logic [WORD_W-1:0] rem_reg;
    logic [WORD_W-1:0] quo_reg;
    logic [WORD_W-1:0] den_reg;
    logic [4:0]        cnt_reg;
    logic              neg_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [WORD_W:0]   rem_sh;
    logic [WORD_W+1:0] diff;
    logic [WORD_W-1:0] num_mag;
    logic [WORD_W-1:0] den_mag;

    assign num_mag = req.num[WORD_W-1] ? WORD_W'(-req.num) : WORD_W'(req.num);
    assign den_mag = req.den[WORD_W-1] ? WORD_W'(-req.den) : WORD_W'(req.den);
    assign rem_sh  = {rem_reg, quo_reg[WORD_W-1]};
    assign diff    = {1'b0, rem_sh} - {2'b00, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            // pulse done after the last quotient step
            done_reg <= busy_reg && !req.start && (cnt_reg == 5'd1);
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'(WORD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= num_mag;
            den_reg <= den_mag;
            neg_reg <= req.num[WORD_W-1] ^ req.den[WORD_W-1];
        end
        else if (busy_reg)
        begin
            // restore when the trial subtract borrows
            if (!diff[WORD_W+1])
            begin
                rem_reg <= diff[WORD_W-1:0];
                quo_reg <= {quo_reg[WORD_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[WORD_W-1:0];
                quo_reg <= {quo_reg[WORD_W-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        rsp.done = done_reg;
        if (neg_reg)
            rsp.quo = -$signed(quo_reg);
        else if (quo_reg[WORD_W-1])
            rsp.quo = {1'b0, {(WORD_W-1){1'b1}}};
        else
            rsp.quo = $signed(quo_reg);
    end

endmodule

/* rtl/crc_checked_sensor_frame_decoder.sv */
// ---------------------------------------------------------------------------
// crc_checked_sensor_frame_decoder
// Byte-stream decoder for CRC-8 protected sensor frames with scaled outputs.
// ---------------------------------------------------------------------------
// Bytes enter on the slave stream, one per beat, with tuser marking the first
// byte of a frame. Each word is two big-endian bytes plus a CRC-8 byte
// (poly 0x31, init 0xFF); a frame carries word_count words: pressure,
// temperature, scale. The input stalls only after the last byte of a frame,
// which starts the result: temperature (frames of two or three words) and
// pressure go through one shared radix-2 divider of 16 steps each, and the
// input stays stalled until the result is in the output register; a bad-CRC
// frame skips the divider. One result beat goes out per complete frame; the
// output register lets the next frame stream in while the result waits.
module crc_checked_sensor_frame_decoder (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [crcfd_pkg::BYTE_W-1:0]  s_tdata,   // [7:0] data_byte
    input  logic                          s_tuser,   // [0] frame_start
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [15:0] pressure_value, [31:16] temperature_value, [47:32] scale_factor,
    // [49:48] status, [55:50] zero
    output logic [crcfd_pkg::OUT_W-1:0]   m_tdata,
    input  logic                          cfg_we,
    input  logic                          cfg_addr,
    input  logic [crcfd_pkg::CFG_W-1:0]   cfg_wdata
);
    import crcfd_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_TDIV = 5'b00010,
        ST_PCHK = 5'b00100,
        ST_PDIV = 5'b01000,
        ST_HOLD = 5'b10000
    } state_t;

    localparam logic [1:0] SUB_HI  = 2'd0;
    localparam logic [1:0] SUB_LO  = 2'd1;
    localparam logic [1:0] SUB_CRC = 2'd2;

    state_t            state_reg;
    logic [1:0]        sub_reg;
    logic [1:0]        widx_reg;
    logic [7:0]        crc_reg;
    logic              fail_reg;
    logic              go_reg;
    logic [WCNT_W-1:0] wcnt_reg;
    logic [TDIV_W-1:0] tdiv_reg;

    logic [7:0]        high_reg;
    logic [WORD_W-1:0] raw_p_reg;
    logic [WORD_W-1:0] raw_t_reg;
    logic [WORD_W-1:0] raw_s_reg;
    logic [WORD_W-1:0] held_s_reg;
    logic [WORD_W-1:0] held_t_reg;
    logic [WORD_W-1:0] res_p_reg;
    logic [STAT_W-1:0] res_st_reg;

    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg;

    logic              accept;
    logic [1:0]        sub_cur;
    logic [1:0]        widx_cur;
    logic [7:0]        crc_cur;
    logic              fail_cur;
    logic [7:0]        crc_new;
    logic              frame_bad;
    logic [WCNT_W-1:0] words;
    logic [TDIV_W-1:0] tdiv_eff;
    logic              out_load;

    div_req_t          div_req;
    div_rsp_t          div_rsp;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid & s_tready;

    // frame_start restarts position, CRC and error flag on this byte
    assign sub_cur   = s_tuser ? SUB_HI   : sub_reg;
    assign widx_cur  = s_tuser ? 2'd0     : widx_reg;
    assign crc_cur   = s_tuser ? CRC_INIT : crc_reg;
    assign fail_cur  = s_tuser ? 1'b0     : fail_reg;
    assign crc_new   = crc8_byte(crc_cur, s_tdata);
    assign frame_bad = fail_cur | (s_tdata != crc_cur);
    assign words     = (wcnt_reg == '0) ? WCNT_W'(1) : wcnt_reg;
    assign tdiv_eff  = (tdiv_reg == '0) ? TDIV_W'(1) : tdiv_reg;

    assign out_load = (state_reg == ST_HOLD) && (!out_valid_reg || m_tready);

    always_comb
    begin
        div_req.start = go_reg;
        if (state_reg == ST_TDIV)
        begin
            div_req.num = $signed(raw_t_reg);
            div_req.den = $signed({1'b0, tdiv_eff});
        end
        else
        begin
            div_req.num = $signed(raw_p_reg);
            div_req.den = $signed(held_s_reg);
        end
    end

    crcfd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wcnt_reg <= WCNT_RESET;
            tdiv_reg <= TDIV_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_WORD_COUNT: wcnt_reg <= cfg_wdata[WCNT_W-1:0];
                CFG_TEMP_DIV:   tdiv_reg <= cfg_wdata[TDIV_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            sub_reg    <= SUB_HI;
            widx_reg   <= 2'd0;
            crc_reg    <= CRC_INIT;
            fail_reg   <= 1'b0;
            go_reg     <= 1'b0;
            held_s_reg <= '0;
            held_t_reg <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (sub_cur)
                            SUB_HI:
                            begin
                                crc_reg  <= crc_new;
                                sub_reg  <= SUB_LO;
                                widx_reg <= widx_cur;
                                fail_reg <= fail_cur;
                            end
                            SUB_LO:
                            begin
                                crc_reg  <= crc_new;
                                sub_reg  <= SUB_CRC;
                                widx_reg <= widx_cur;
                                fail_reg <= fail_cur;
                            end
                            default:
                            begin
                                crc_reg <= CRC_INIT;
                                sub_reg <= SUB_HI;
                                if ({1'b0, widx_cur} + 3'd1 < {1'b0, words})
                                begin
                                    widx_reg <= widx_cur + 2'd1;
                                    fail_reg <= frame_bad;
                                end
                                else
                                begin
                                    // frame complete
                                    widx_reg <= 2'd0;
                                    fail_reg <= 1'b0;
                                    if (frame_bad)
                                        state_reg <= ST_HOLD;
                                    else
                                    begin
                                        if (words == 2'd3)
                                            held_s_reg <= raw_s_reg;
                                        if (words inside {2'd2, 2'd3})
                                        begin
                                            state_reg <= ST_TDIV;
                                            go_reg    <= 1'b1;
                                        end
                                        else
                                            state_reg <= ST_PCHK;
                                    end
                                end
                            end
                        endcase
                    end
                end
                ST_TDIV:
                begin
                    go_reg <= 1'b0;
                    if (div_rsp.done)
                    begin
                        held_t_reg <= div_rsp.quo;
                        state_reg  <= ST_PCHK;
                    end
                end
                ST_PCHK:
                begin
                    if (held_s_reg == '0)
                        state_reg <= ST_HOLD;
                    else
                    begin
                        state_reg <= ST_PDIV;
                        go_reg    <= 1'b1;
                    end
                end
                ST_PDIV:
                begin
                    go_reg <= 1'b0;
                    if (div_rsp.done)
                        state_reg <= ST_HOLD;
                end
                ST_HOLD:
                begin
                    if (out_load)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    go_reg    <= 1'b0;
                end
            endcase
        end
    end

    // datapath registers without reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (sub_cur == SUB_HI)
                high_reg <= s_tdata;
            else if (sub_cur == SUB_LO)
            begin
                case (widx_cur)
                    2'd0:    raw_p_reg <= {high_reg, s_tdata};
                    2'd1:    raw_t_reg <= {high_reg, s_tdata};
                    default: raw_s_reg <= {high_reg, s_tdata};
                endcase
            end
            else if (frame_bad)
            begin
                res_p_reg  <= '0;
                res_st_reg <= STATUS_CRC;
            end
        end
        if (state_reg == ST_PCHK && held_s_reg == '0)
        begin
            res_p_reg  <= '0;
            res_st_reg <= STATUS_ZERO;
        end
        if (state_reg == ST_PDIV && div_rsp.done)
        begin
            res_p_reg  <= div_rsp.quo;
            res_st_reg <= STATUS_OK;
        end
        if (out_load)
            out_data_reg <= {{(OUT_W-3*WORD_W-STAT_W){1'b0}}, res_st_reg,
                             held_s_reg, held_t_reg, res_p_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* rtl/crcfd_checker.sv */
// ---------------------------------------------------------------------------
// crcfd_checker
// Port-level checks for the frame decoder, attached by bind.
// ---------------------------------------------------------------------------
module crcfd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [crcfd_pkg::OUT_W-1:0]   m_tdata
);
    import crcfd_pkg::*;

    logic [STAT_W-1:0] st;
    assign st = m_tdata[3*WORD_W+STAT_W-1:3*WORD_W];

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (st == STATUS_OK || st == STATUS_CRC || st == STATUS_ZERO))
        else $error("undefined status code");

    // an error result carries no pressure
    a_err_pres: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && st != STATUS_OK |-> m_tdata[WORD_W-1:0] == '0)
        else $error("pressure nonzero on error result");

    // a new result follows the frame-end work, during which input is stalled
    a_new_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared while input was being taken");

endmodule

bind crc_checked_sensor_frame_decoder crcfd_checker u_crcfd_checker (.*);
